/* hw/rtl/ulti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulti_pkg
// Types and constants shared by the undirected link table insert block.
// ----------------------------------------------------------------------------
package ulti_pkg;

    localparam int MAX_LINKS_DEF     = 256;
    localparam int NODE_BITS_DEF     = 16;
    localparam int STRENGTH_BITS_DEF = 8;

    localparam int NODE_FIELD_W  = 16;
    localparam int ACTION_W      = 2;
    localparam int INDEX_FIELD_W = 8;
    localparam int STR_FIELD_W   = 8;
    localparam int COUNT_FIELD_W = 9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND  = 2'd0,
        ACT_RAISED  = 2'd1,
        ACT_REVERSE = 2'd2,
        ACT_FULL    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_action                    action;
        logic [INDEX_FIELD_W-1:0]   entry_index;
        logic [STR_FIELD_W-1:0]     strength;
        logic [COUNT_FIELD_W-1:0]   entry_count;
    } t_result;

endpackage

/* hw/rtl/ulti_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulti_link_if / ulti_result_if
// Valid/ready channels for link beats in and result beats out.
// ----------------------------------------------------------------------------
interface ulti_link_if import ulti_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [NODE_FIELD_W-1:0] from_node;
    logic [NODE_FIELD_W-1:0] to_node;

    modport source (output valid, output from_node, output to_node, input ready);
    modport sink   (input valid, input from_node, input to_node, output ready);
endinterface

interface ulti_result_if import ulti_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [INDEX_FIELD_W-1:0] entry_index;
    logic [STR_FIELD_W-1:0]   strength;
    logic [COUNT_FIELD_W-1:0] entry_count;

    modport source (output valid, output action, output entry_index, output strength,
                    output entry_count, input ready);
    modport sink   (input valid, input action, input entry_index, input strength,
                    input entry_count, output ready);
endinterface

/* hw/rtl/ulti_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulti_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ulti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ulti_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulti_ctrl
// Scan sequencer: reads the table in order, tracks exact and reversed
// matches, then raises, appends or reports when the result is committed.
// ----------------------------------------------------------------------------
module ulti_ctrl import ulti_pkg::*; #(
    parameter int MAX_LINKS     = MAX_LINKS_DEF,
    parameter int NODE_BITS     = NODE_BITS_DEF,
    parameter int STRENGTH_BITS = STRENGTH_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ulti_link_if.sink                              i_link,
    input  logic                                   i_out_free,
    output logic                                   o_push,
    output t_result                                o_result,
    output logic                                   o_ram_we,
    output logic [$clog2(MAX_LINKS)-1:0]           o_ram_waddr,
    output logic [2*NODE_BITS+STRENGTH_BITS-1:0]   o_ram_wdata,
    output logic [$clog2(MAX_LINKS)-1:0]           o_ram_raddr,
    input  logic [2*NODE_BITS+STRENGTH_BITS-1:0]   i_ram_rdata
);

    localparam int AW = $clog2(MAX_LINKS);
    localparam int CW = $clog2(MAX_LINKS + 1);
    localparam int SB = STRENGTH_BITS;
    localparam int DW = 2 * NODE_BITS + STRENGTH_BITS;

    t_state                r_state, n_state;
    logic [NODE_BITS-1:0]  r_from, n_from;
    logic [NODE_BITS-1:0]  r_to, n_to;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_issue, n_issue;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_pend_idx, n_pend_idx;
    logic                  r_hit, n_hit;
    logic [AW-1:0]         r_hit_idx, n_hit_idx;
    logic [SB-1:0]         r_hit_str, n_hit_str;
    logic                  r_rev, n_rev;
    logic [AW-1:0]         r_rev_idx, n_rev_idx;
    logic [SB-1:0]         r_rev_str, n_rev_str;

    logic [NODE_BITS-1:0]               rd_start;
    logic [NODE_BITS-1:0]               rd_end;
    logic [SB-1:0]                      rd_str;
    logic [SB-1:0]                      sat_str;
    logic                               more;
    logic                               exact;
    logic                               rev;
    logic [NODE_BITS+NODE_FIELD_W-1:0]  from_ext;
    logic [NODE_BITS+NODE_FIELD_W-1:0]  to_ext;
    t_action                            sel_act;
    logic [AW-1:0]                      sel_idx;
    logic [SB-1:0]                      sel_str;
    logic [AW+INDEX_FIELD_W-1:0]        idx_ext;
    logic [SB+STR_FIELD_W-1:0]          str_ext;
    logic [CW+COUNT_FIELD_W-1:0]        cnt_ext;

    assign rd_start = i_ram_rdata[DW-1 -: NODE_BITS];
    assign rd_end   = i_ram_rdata[SB +: NODE_BITS];
    assign rd_str   = i_ram_rdata[SB-1:0];
    assign sat_str  = (&rd_str) ? rd_str : rd_str + SB'(1);
    assign more     = r_issue < r_count;
    assign exact    = r_pend && (rd_start == r_from) && (rd_end == r_to);
    assign rev      = r_pend && !r_rev && (rd_start == r_to) && (rd_end == r_from);
    assign from_ext = {{NODE_BITS{1'b0}}, i_link.from_node};
    assign to_ext   = {{NODE_BITS{1'b0}}, i_link.to_node};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from     <= n_from;
        r_to       <= n_to;
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_str  <= n_hit_str;
        r_rev      <= n_rev;
        r_rev_idx  <= n_rev_idx;
        r_rev_str  <= n_rev_str;
    end

    always_comb begin
        n_state     = r_state;
        n_from      = r_from;
        n_to        = r_to;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_str   = r_hit_str;
        n_rev       = r_rev;
        n_rev_idx   = r_rev_idx;
        n_rev_str   = r_rev_str;
        i_link.ready = 1'b0;
        o_push      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = {r_from, r_to, SB'(1)};
        o_ram_raddr = r_issue[AW-1:0];
        sel_idx     = '0;
        sel_str     = '0;
        sel_act     = ACT_FULL;

        case (r_state)
            ST_IDLE: begin
                i_link.ready = 1'b1;
                if (i_link.valid) begin
                    n_from  = from_ext[NODE_BITS-1:0];
                    n_to    = to_ext[NODE_BITS-1:0];
                    n_issue = '0;
                    n_hit   = 1'b0;
                    n_rev   = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read of the next slot overlaps the compare of the previous one
                n_pend     = more && !exact;
                n_pend_idx = r_issue[AW-1:0];
                if (more) begin
                    n_issue = r_issue + CW'(1);
                end
                if (exact) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_pend_idx;
                    n_hit_str = sat_str;
                end
                if (rev) begin
                    n_rev     = 1'b1;
                    n_rev_idx = r_pend_idx;
                    n_rev_str = rd_str;
                end
                if (exact || !more) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (r_hit) begin
                    sel_act     = ACT_RAISED;
                    sel_idx     = r_hit_idx;
                    sel_str     = r_hit_str;
                    o_ram_waddr = r_hit_idx;
                    o_ram_wdata = {r_from, r_to, r_hit_str};
                end else if (r_rev) begin
                    sel_act     = ACT_REVERSE;
                    sel_idx     = r_rev_idx;
                    sel_str     = r_rev_str;
                end else if (r_count == CW'(MAX_LINKS)) begin
                    sel_act     = ACT_FULL;
                end else begin
                    sel_act     = ACT_APPEND;
                    sel_idx     = r_count[AW-1:0];
                    sel_str     = SB'(1);
                end
                if (i_out_free) begin
                    o_push   = 1'b1;
                    o_ram_we = r_hit || (!r_rev && (r_count != CW'(MAX_LINKS)));
                    if (!r_hit && !r_rev && (r_count != CW'(MAX_LINKS))) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // count after the step, as reported
    always_comb begin
        idx_ext = {{INDEX_FIELD_W{1'b0}}, sel_idx};
        str_ext = {{STR_FIELD_W{1'b0}}, sel_str};
        if (!r_hit && !r_rev && (r_count != CW'(MAX_LINKS))) begin
            cnt_ext = {{COUNT_FIELD_W{1'b0}}, r_count + CW'(1)};
        end else begin
            cnt_ext = {{COUNT_FIELD_W{1'b0}}, r_count};
        end
        o_result.action      = sel_act;
        o_result.entry_index = idx_ext[INDEX_FIELD_W-1:0];
        o_result.strength    = str_ext[STR_FIELD_W-1:0];
        o_result.entry_count = cnt_ext[COUNT_FIELD_W-1:0];
    end

endmodule

/* hw/rtl/ulti_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulti_out
// Output register holding one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ulti_out import ulti_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_result        i_result,
    output logic           o_free,
    ulti_result_if.source  o_result
);

    logic    r_valid, n_valid;
    t_result r_data, n_data;

    assign o_free = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_result.ready) begin
            n_valid = 1'b0;
        end
        if (i_push) begin
            n_valid = 1'b1;
            n_data  = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_result.valid       = r_valid;
    assign o_result.action      = r_data.action;
    assign o_result.entry_index = r_data.entry_index;
    assign o_result.strength    = r_data.strength;
    assign o_result.entry_count = r_data.entry_count;

endmodule

/* hw/rtl/undirected_link_table_insert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// undirected_link_table_insert
// Link table with multiplicity counts; one result beat per link beat.
// ----------------------------------------------------------------------------
// Each link beat scans the stored links in insertion order, one table read
// per cycle from a single registered-read RAM. An exact match raises that
// link's strength (saturating) and ends the scan; a reversed match is noted
// and reported if no exact match follows; otherwise the link is appended with
// strength 1, or dropped and flagged when the table is full. The scan visits
// every stored link when no exact match is found and ends early on an exact
// match. One beat is worked on at a time, and a new link beat is taken while
// the previous result still waits in the output register. The table needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module undirected_link_table_insert import ulti_pkg::*; #(
    parameter int MAX_LINKS     = MAX_LINKS_DEF,
    parameter int NODE_BITS     = NODE_BITS_DEF,
    parameter int STRENGTH_BITS = STRENGTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ulti_link_if.sink     i_link,
    ulti_result_if.source o_result
);

    localparam int AW = $clog2(MAX_LINKS);
    localparam int DW = 2 * NODE_BITS + STRENGTH_BITS;

    logic          w_push;
    logic          w_free;
    t_result       w_result;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [DW-1:0] w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic [DW-1:0] w_ram_rdata;

    ulti_ctrl #(
        .MAX_LINKS     (MAX_LINKS),
        .NODE_BITS     (NODE_BITS),
        .STRENGTH_BITS (STRENGTH_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_link      (i_link),
        .i_out_free  (w_free),
        .o_push      (w_push),
        .o_result    (w_result),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    ulti_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LINKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    ulti_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_free   (w_free),
        .o_result (o_result)
    );

    a_write_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> w_push)
        else $error("table write outside a commit");

    a_commit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_free)
        else $error("result pushed into a full output register");

    a_store_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && (w_result.action == ACT_APPEND || w_result.action == ACT_RAISED)
        |-> w_ram_we)
        else $error("append or raise without a table write");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_result.valid)
        else $error("pushed result beat not presented");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.action == ACT_FULL
        |-> o_result.entry_index == '0 && o_result.strength == '0)
        else $error("dropped beat reports nonzero slot or strength");

endmodule
